/* hw/rtl/bsa_pkg.sv */
// shared types and constants of the bitmap slab allocator
// used by every module under hw/rtl, depends on nothing
package bsa_pkg;

  localparam int ADDR_W    = 48;
  localparam int STRIDE_W  = 21;
  localparam int SIZE_W    = 16;
  localparam int CNT_W     = 32;
  localparam int SLAB_W    = 5;
  localparam int OBJ_W     = 7;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_W     = 16;

  localparam int CACHES_DEF          = 4;
  localparam int SLABS_PER_CACHE_DEF = 32;
  localparam int MAX_OBJECTS_DEF     = 128;

  localparam logic [DIV_W-1:0]    PAGE_BYTES  = 16'd4096;
  localparam logic [STRIDE_W-1:0] STRIDE_RST  = 21'd4096;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOSLAB   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE0  = 3'd2;

  typedef struct packed {
    logic              opcode;
    logic [1:0]        cache_index;
    logic [ADDR_W-1:0] free_address;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] object_address;
    logic [SLAB_W-1:0] slab_number;
    logic [OBJ_W-1:0]  object_number;
    logic              grew;
    logic [CNT_W-1:0]  alloc_total;
    logic [CNT_W-1:0]  free_total;
  } out_t;

  typedef struct packed {
    logic              load;
    logic              prod;
    logic              base_init;
    logic              div_n_start;
    logic              div_f_start;
    logic              n_latch;
    logic              lim;
    logic              rd;
    logic              step;
    logic              a_take;
    logic              grow;
    logic              obj_prod;
    logic              addr_sum;
    logic              f_take;
    logic              f_write;
    logic              set_st;
    logic [STAT_W-1:0] st_code;
    logic              emit;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic div_done;
    logic s_end;
    logic full;
    logic hit;
    logic fhit;
    logic op;
  } sts_t;

endpackage

/* hw/rtl/bsa_div.sv */
// serial restoring divider, one quotient bit per cycle
// depends on bsa_pkg
module bsa_div import bsa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam int CW = $clog2(DIV_W);

  logic             busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DIV_W:0]   rem_q, rem_d;
  logic [DIV_W-1:0] dvd_q, dvd_d, dsr_q, dsr_d;
  logic [DIV_W:0]   rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_sh = {rem_q[DIV_W-1:0], dvd_q[DIV_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dsr_q}) begin
        rem_d = rem_sh - {1'b0, dsr_q};
        dvd_d = {dvd_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        dvd_d = {dvd_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");

endmodule

/* hw/rtl/bsa_ctrl.sv */
// sequencing state machine of the slab allocator
// depends on bsa_pkg, drives bsa_dp through cmd_t and reads sts_t
module bsa_ctrl import bsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_DIVN  = 4'd2;
  localparam logic [3:0] S_LIM   = 4'd3;
  localparam logic [3:0] S_AREQ  = 4'd4;
  localparam logic [3:0] S_AWAIT = 4'd5;
  localparam logic [3:0] S_ADDR  = 4'd6;
  localparam logic [3:0] S_SUM   = 4'd7;
  localparam logic [3:0] S_FCMP  = 4'd8;
  localparam logic [3:0] S_FDIV  = 4'd9;
  localparam logic [3:0] S_FRD   = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  cmd_t       cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.bad) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = ST_BAD;
          state_d     = S_FIN;
        end else begin
          cmd.div_n_start = 1'b1;
          cmd.prod        = 1'b1;
          state_d         = S_DIVN;
        end
      end
      S_DIVN: begin
        cmd.base_init = 1'b1;
        if (sts_i.div_done) begin
          cmd.n_latch = 1'b1;
          state_d     = S_LIM;
        end
      end
      S_LIM: begin
        cmd.lim = 1'b1;
        state_d = (sts_i.op == OP_ALLOC) ? S_AREQ : S_FCMP;
      end
      S_AREQ: begin
        if (sts_i.s_end) begin
          if (sts_i.full) begin
            cmd.set_st  = 1'b1;
            cmd.st_code = ST_NOSLAB;
            state_d     = S_FIN;
          end else begin
            cmd.grow = 1'b1;
            state_d  = S_ADDR;
          end
        end else begin
          cmd.rd  = 1'b1;
          state_d = S_AWAIT;
        end
      end
      S_AWAIT: begin
        if (sts_i.hit) begin
          cmd.a_take = 1'b1;
          state_d    = S_ADDR;
        end else begin
          cmd.step = 1'b1;
          state_d  = S_AREQ;
        end
      end
      S_ADDR: begin
        cmd.obj_prod = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd.addr_sum = 1'b1;
        state_d      = S_FIN;
      end
      S_FCMP: begin
        if (sts_i.s_end) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = ST_NOTFOUND;
          state_d     = S_FIN;
        end else if (sts_i.fhit) begin
          cmd.div_f_start = 1'b1;
          state_d         = S_FDIV;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FDIV: begin
        if (sts_i.div_done) begin
          cmd.f_take = 1'b1;
          cmd.rd     = 1'b1;
          state_d    = S_FRD;
        end
      end
      S_FRD: begin
        cmd.f_write = 1'b1;
        state_d     = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.emit = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  a_grow_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.grow |-> !sts_i.full) else $error("slab grown in a full cache");

  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN)
    else $error("result shown outside finish state");

endmodule

/* hw/rtl/bsa_dp.sv */
// datapath: config registers, bitmap memory, slab walk, counters, result register
// depends on bsa_pkg and bsa_div
module bsa_dp import bsa_pkg::*; #(
  parameter int CACHES          = CACHES_DEF,
  parameter int SLABS_PER_CACHE = SLABS_PER_CACHE_DEF,
  parameter int MAX_OBJECTS     = MAX_OBJECTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  input  in_t                  in_data_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output out_t                 out_data_o
);

  localparam int SW  = $clog2(SLABS_PER_CACHE + 1);
  localparam int RN  = CACHES * SLABS_PER_CACHE;
  localparam int RW  = (RN > 1) ? $clog2(RN) : 1;
  localparam int NW  = $clog2(MAX_OBJECTS + 1);
  localparam int CIW = (CACHES > 1) ? $clog2(CACHES) : 1;
  localparam int PW  = RW + STRIDE_W;
  localparam int LW  = NW + SIZE_W;
  localparam int QW  = OBJ_W + SIZE_W;

  logic [ADDR_W-1:0]   region_q;
  logic [STRIDE_W-1:0] stride_q;
  logic [SIZE_W-1:0]   size_q [CACHES];

  logic [SW-1:0]       in_use_q [CACHES];
  logic [CNT_W-1:0]    acnt_q [CACHES];
  logic [CNT_W-1:0]    fcnt_q [CACHES];

  logic [MAX_OBJECTS-1:0] mem [RN];
  logic [MAX_OBJECTS-1:0] rd_q;

  in_t               req_q;
  logic [SW-1:0]     s_q;
  logic [PW-1:0]     prod_q;
  logic [ADDR_W-1:0] base_q;
  logic [NW-1:0]     n_q;
  logic [LW-1:0]     lim_q;
  logic [QW-1:0]     oprod_q;
  logic [STAT_W-1:0] st_q;
  logic [SLAB_W-1:0] slab_q;
  logic [OBJ_W-1:0]  obj_q;
  logic              grew_q;
  logic [ADDR_W-1:0] oaddr_q;
  out_t              out_q;

  logic                   ci_ok;
  logic [CIW-1:0]         cidx;
  logic [SIZE_W-1:0]      size_cur;
  logic [SW-1:0]          used;
  logic [RW-1:0]          row;
  logic [MAX_OBJECTS-1:0] mask, masked, oh_enc, oh_obj, wdata;
  logic [OBJ_W-1:0]       enc;
  logic                   hit, fhit, wen;
  logic [ADDR_W-1:0]      off;
  logic                   div_done, div_start;
  logic [DIV_W-1:0]       quot, dividend;
  logic [NW-1:0]          n_new;
  logic                   inc_a, inc_f;

  assign ci_ok    = 32'(req_q.cache_index) < CACHES;
  assign cidx     = req_q.cache_index[CIW-1:0];
  assign size_cur = ci_ok ? size_q[cidx] : '0;
  assign used     = in_use_q[cidx];
  assign row      = RW'(cidx) * RW'(SLABS_PER_CACHE) + RW'(s_q);
  assign off      = req_q.free_address - base_q;
  assign fhit     = off < ADDR_W'(lim_q);

  always_comb begin
    enc = '0;
    for (int i = 0; i < MAX_OBJECTS; i++) begin
      mask[i]   = NW'(i) < n_q;
      masked[i] = rd_q[i] & mask[i];
      oh_obj[i] = OBJ_W'(i) == obj_q;
    end
    for (int i = MAX_OBJECTS - 1; i >= 0; i--) begin
      if (masked[i]) enc = OBJ_W'(i);
    end
    for (int i = 0; i < MAX_OBJECTS; i++) begin
      oh_enc[i] = OBJ_W'(i) == enc;
    end
  end
  assign hit = |masked;

  // objects per slab, clamped to one..MAX_OBJECTS
  always_comb begin
    if (quot > DIV_W'(MAX_OBJECTS)) begin
      n_new = NW'(MAX_OBJECTS);
    end else if (quot == '0) begin
      n_new = NW'(1);
    end else begin
      n_new = NW'(quot);
    end
  end

  assign div_start = cmd_i.div_n_start | cmd_i.div_f_start;
  assign dividend  = cmd_i.div_f_start ? off[DIV_W-1:0] : PAGE_BYTES;

  bsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (size_cur),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // bitmap row writes
  always_comb begin
    wen   = 1'b0;
    wdata = rd_q;
    if (cmd_i.a_take) begin
      wen   = 1'b1;
      wdata = rd_q & ~oh_enc;
    end else if (cmd_i.grow) begin
      wen   = 1'b1;
      wdata = mask & ~MAX_OBJECTS'(1);
    end else if (cmd_i.f_write) begin
      wen   = 1'b1;
      wdata = rd_q | oh_obj;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) mem[row] <= wdata;
    if (cmd_i.rd) rd_q <= mem[row];
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= '0;
      stride_q <= STRIDE_RST;
      for (int k = 0; k < CACHES; k++) size_q[k] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_REGION: region_q <= cfg_data_i;
        CFG_STRIDE: stride_q <= cfg_data_i[STRIDE_W-1:0];
        default: begin
          for (int k = 0; k < CACHES; k++) begin
            if (cfg_index_i == CFG_SIZE0 + CFG_IDX_W'(k)) size_q[k] <= cfg_data_i[SIZE_W-1:0];
          end
        end
      endcase
    end
  end

  assign inc_a = (st_q == ST_OK) && (req_q.opcode == OP_ALLOC) && ci_ok;
  assign inc_f = (st_q == ST_OK) && (req_q.opcode == OP_FREE) && ci_ok;

  // per-cache state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CACHES; k++) begin
        in_use_q[k] <= '0;
        acnt_q[k]   <= '0;
        fcnt_q[k]   <= '0;
      end
    end else begin
      if (cmd_i.grow) in_use_q[cidx] <= used + SW'(1);
      if (cmd_i.emit && inc_a) acnt_q[cidx] <= acnt_q[cidx] + CNT_W'(1);
      if (cmd_i.emit && inc_f) fcnt_q[cidx] <= fcnt_q[cidx] + CNT_W'(1);
    end
  end

  // walk and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= in_data_i;
      s_q     <= '0;
      st_q    <= ST_OK;
      slab_q  <= '0;
      obj_q   <= '0;
      grew_q  <= 1'b0;
      oaddr_q <= '0;
    end
    if (cmd_i.prod) prod_q <= PW'(row) * PW'(stride_q);
    if (cmd_i.base_init) base_q <= region_q + ADDR_W'(prod_q);
    if (cmd_i.step) begin
      s_q    <= s_q + SW'(1);
      base_q <= base_q + ADDR_W'(stride_q);
    end
    if (cmd_i.n_latch) n_q <= n_new;
    if (cmd_i.lim) lim_q <= LW'(n_q) * LW'(size_cur);
    if (cmd_i.a_take) begin
      slab_q <= SLAB_W'(s_q);
      obj_q  <= enc;
    end
    if (cmd_i.grow) begin
      slab_q <= SLAB_W'(s_q);
      obj_q  <= '0;
      grew_q <= 1'b1;
    end
    if (cmd_i.div_f_start) slab_q <= SLAB_W'(s_q);
    if (cmd_i.f_take) obj_q <= quot[OBJ_W-1:0];
    if (cmd_i.obj_prod) oprod_q <= QW'(obj_q) * QW'(size_cur);
    if (cmd_i.addr_sum) oaddr_q <= base_q + ADDR_W'(oprod_q);
    if (cmd_i.set_st) st_q <= cmd_i.st_code;
    if (cmd_i.emit) begin
      out_q.status         <= st_q;
      out_q.object_address <= oaddr_q;
      out_q.slab_number    <= slab_q;
      out_q.object_number  <= obj_q;
      out_q.grew           <= grew_q;
      out_q.alloc_total    <= ci_ok ? acnt_q[cidx] + CNT_W'(inc_a) : '0;
      out_q.free_total     <= ci_ok ? fcnt_q[cidx] + CNT_W'(inc_f) : '0;
    end
  end

  assign sts_o.bad      = !ci_ok || (size_cur == '0);
  assign sts_o.div_done = div_done;
  assign sts_o.s_end    = s_q == used;
  assign sts_o.full     = used == SW'(SLABS_PER_CACHE);
  assign sts_o.hit      = hit;
  assign sts_o.fhit     = fhit;
  assign sts_o.op       = req_q.opcode;
  assign out_data_o     = out_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ci_ok |-> used <= SW'(SLABS_PER_CACHE)) else $error("slab count overflow");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && st_q != ST_OK) |-> (oaddr_q == '0 && grew_q == 1'b0))
    else $error("failed request carries an address");

endmodule

/* hw/rtl/bitmap_slab_allocator.sv */
// Fixed-size object allocator: one request at a time, one result per request.
// A bad or inactive cache is answered without dividing or walking the slabs.
// Otherwise the 16-step serial divider first works out objects per slab, then
// an allocate reads one bitmap row per slab scanned, and a free compares the
// slabs in turn, then divides the offset and updates the bitmap. The bitmap
// memory has one read and one write port, and its contents are undefined
// until a slab is grown.
// Depends on bsa_pkg, bsa_ctrl, bsa_dp and bsa_div.
module bitmap_slab_allocator import bsa_pkg::*; #(
  parameter int CACHES          = CACHES_DEF,
  parameter int SLABS_PER_CACHE = SLABS_PER_CACHE_DEF,
  parameter int MAX_OBJECTS     = MAX_OBJECTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  bsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bsa_dp #(
    .CACHES          (CACHES),
    .SLABS_PER_CACHE (SLABS_PER_CACHE),
    .MAX_OBJECTS     (MAX_OBJECTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule
